>>> rtl/sorted_min_priority_queue_core_assert.svh
// Assertion macros used by the top level of the sorted minimum priority queue.
`ifndef SORTED_MIN_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_MIN_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SMPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smpq same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SMPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smpq next-cycle check failed");

`endif

>>> rtl/smpq_pkg.sv
// Shared constants and types of the sorted minimum priority queue.
`default_nettype none

package smpq_pkg;

    localparam int DEPTH         = 16;
    localparam int CNT_W         = $clog2(DEPTH + 1);
    localparam int VALUE_W       = 32;
    localparam int ENTRY_COUNT_W = 5;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    localparam logic [VALUE_W-1:0] UNDERFLOW_VALUE = '1;

    // Operation broadcast to every cell in the chain.
    typedef struct packed {
        logic insert;
        logic remove;
    } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/smpq_cell.sv
// One storage cell of the sorted queue chain: holds an entry and shifts with its neighbours.
`default_nettype none

module smpq_cell
    import smpq_pkg::*;
(
    input  wire logic               clk,
    input  wire cell_ctl_t          ctl,
    input  wire logic               occupied,
    input  wire logic [VALUE_W-1:0] new_value,
    input  wire logic               left_take,
    input  wire logic [VALUE_W-1:0] left_entry,
    input  wire logic [VALUE_W-1:0] right_entry,
    output logic                    take,
    output logic [VALUE_W-1:0]      entry
);

    logic [VALUE_W-1:0] entry_reg;
    logic [VALUE_W-1:0] entry_next;

    // A cell takes part in an insert when it is free or holds a strictly larger value.
    // The chain is sorted, so these flags form a run that starts at the insert point.
    assign take  = !occupied || ($signed(entry_reg) > $signed(new_value));
    assign entry = entry_reg;

    always_comb
    begin
        priority if (ctl.insert && take)
        begin
            // The first taking cell receives the new value, the rest shift up by one.
            entry_next = left_take ? left_entry : new_value;
        end
        else if (ctl.remove)
        begin
            entry_next = right_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

>>> rtl/sorted_min_priority_queue_core.sv
// Top level of the sorted minimum priority queue built as a chain of shifting cells.
//
// Usage: each item on the s_axis channel is one operation. s_axis_tuser selects it (0 inserts
// s_axis_tdata as a signed 32-bit value, 1 removes the smallest stored value). Every item yields
// exactly one result item on the m_axis channel carrying the removed value, the underflow and
// overflow flags, the entry count after the operation and an empty flag.
// Inserts are placed after all stored values that are equal, so equal values leave in arrival
// order. A removal from an empty queue returns -1 with underflow set; an insert into a full queue
// is dropped with overflow set and the contents unchanged.
// The result is registered: it is in the output register at the edge after acceptance.
// Throughput is one item per cycle while the receiver does not stall, because every cell compares
// and shifts in parallel and the entry count register is updated in the same cycle.
// When the receiver stalls, the pending result is held and one further item can still be taken
// only if the output register is being emptied in the same cycle; otherwise s_axis_tready falls.
// Reset clears the entry count and the output valid flag; the cell contents are not cleared, as
// only cells below the count are ever read.
`default_nettype none

module sorted_min_priority_queue_core
    import smpq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value
    input  wire logic        s_axis_tuser,   // [0] mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata    // [31:0] out_value, [32] underflow, [33] overflow,
                                             // [38:34] entry_count, [39] is_empty
);

    `include "sorted_min_priority_queue_core_assert.svh"

    // Entry count and the registered result.
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [VALUE_W-1:0]       out_value_reg;
    logic [VALUE_W-1:0]       out_value_next;
    logic                     underflow_reg;
    logic                     underflow_next;
    logic                     overflow_reg;
    logic                     overflow_next;
    logic [ENTRY_COUNT_W-1:0] entry_count_reg;
    logic [ENTRY_COUNT_W-1:0] entry_count_next;
    logic                     is_empty_reg;
    logic                     is_empty_next;

    logic      in_fire;
    logic      full;
    logic      empty;
    cell_ctl_t ctl;

    logic               take_w  [DEPTH];
    logic [VALUE_W-1:0] entry_w [DEPTH];

    // The output register accepts a new result when it is empty or being drained.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign empty = (cnt_reg == '0);

    assign ctl.insert = in_fire && (s_axis_tuser == MODE_INSERT) && !full;
    assign ctl.remove = in_fire && (s_axis_tuser == MODE_REMOVE) && !empty;

    // The cell chain: each cell sees its left neighbour for inserts and its right one for removals.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic               occupied;
        logic               left_take;
        logic [VALUE_W-1:0] left_entry;
        logic [VALUE_W-1:0] right_entry;

        assign occupied = (CNT_W'(i) < cnt_reg);

        if (i == 0)
        begin : g_head
            assign left_take  = 1'b0;
            assign left_entry = s_axis_tdata;
        end
        else
        begin : g_body
            assign left_take  = take_w[i-1];
            assign left_entry = entry_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_entry = '0;
        end
        else
        begin : g_inner
            assign right_entry = entry_w[i+1];
        end

        smpq_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .occupied    (occupied),
            .new_value   (s_axis_tdata),
            .left_take   (left_take),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .take        (take_w[i]),
            .entry       (entry_w[i])
        );
    end

    // Next count and the result of the accepted item.
    always_comb
    begin
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg;
        out_value_next   = out_value_reg;
        underflow_next   = underflow_reg;
        overflow_next    = overflow_reg;
        entry_count_next = entry_count_reg;
        is_empty_next    = is_empty_reg;

        if (ctl.insert)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (ctl.remove)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (in_fire)
        begin
            out_valid_next   = 1'b1;
            underflow_next   = (s_axis_tuser == MODE_REMOVE) && empty;
            overflow_next    = (s_axis_tuser == MODE_INSERT) && full;
            entry_count_next = ENTRY_COUNT_W'(cnt_next);
            is_empty_next    = (cnt_next == '0);
            unique case (s_axis_tuser)
                MODE_INSERT: out_value_next = '0;
                MODE_REMOVE: out_value_next = empty ? UNDERFLOW_VALUE : entry_w[0];
                default:     out_value_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg   <= out_value_next;
        underflow_reg   <= underflow_next;
        overflow_reg    <= overflow_next;
        entry_count_reg <= entry_count_next;
        is_empty_reg    <= is_empty_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {is_empty_reg, entry_count_reg, overflow_reg, underflow_reg,
                            out_value_reg};

    // The count never runs past the number of cells.
    `SMPQ_ASSERT_NOW(a_cnt_bounded, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(DEPTH))
    // An accepted insert into a queue with room grows the count by one.
    `SMPQ_ASSERT_NEXT(a_insert_grows, clk, rst_n, ctl.insert, cnt_reg == $past(cnt_reg) + CNT_W'(1))
    // An underflow result always carries the sentinel value and an empty queue.
    `SMPQ_ASSERT_NOW(a_underflow_value, clk, rst_n, out_valid_reg && underflow_reg,
                     (out_value_reg == UNDERFLOW_VALUE) && is_empty_reg)
    // The input side only stalls while a result is waiting for a stalled receiver.
    `SMPQ_ASSERT_NOW(a_stall_cause, clk, rst_n, !s_axis_tready, out_valid_reg && !m_axis_tready)

endmodule

`default_nettype wire
